### hw/rtl/lpp_pkg.sv
// Shared types, widths and helpers of the lidar point projection block.
`timescale 1ns / 1ps
package lpp_pkg;

	localparam int PT_W    = 24;  // Q8.16 point and camera coordinates
	localparam int COEF_W  = 16;  // rotation, translation, focal, principal fields
	localparam int PROD_W  = PT_W + COEF_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int CAM_W   = ACC_W - 14;
	localparam int NUM_W   = CAM_W + COEF_W + 1;
	localparam int DIV_STEPS = 21;             // quotient bits kept below the clamp
	localparam int Q_W     = DIV_STEPS + 1;
	localparam int PIX_W   = 16;
	localparam int UPIX_W  = 24;
	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;

	typedef enum logic [1:0] {
		ST_VISIBLE   = 2'd0,
		ST_DEPTH_BAD = 2'd1,
		ST_OUTSIDE   = 2'd2
	} lpp_status_t;

	typedef enum logic [2:0] {
		REG_ROT0  = 3'd0,
		REG_ROT1  = 3'd1,
		REG_ROT2  = 3'd2,
		REG_TRANS = 3'd3,
		REG_FOCAL = 3'd4,
		REG_PRIN  = 3'd5,
		REG_IMG   = 3'd6,
		REG_MAXD  = 3'd7
	} lpp_reg_t;

	// Data that rides alongside the divider stages.
	typedef struct packed {
		logic [PT_W-1:0] cam_x;
		logic [PT_W-1:0] cam_y;
		logic [PT_W-1:0] cam_z;
		logic            depth_bad;
		logic            depth_zero;
		logic            neg_u;
		logic            neg_v;
	} lpp_side_t;

	function automatic logic [PT_W-1:0] sat_cam(input logic signed [CAM_W-1:0] v);
		logic signed [CAM_W-1:0] hi;
		logic signed [CAM_W-1:0] lo;
		hi = CAM_W'(2 ** (PT_W - 1) - 1);
		lo = -CAM_W'(2 ** (PT_W - 1));
		if (v > hi)
			sat_cam = hi[PT_W-1:0];
		else if (v < lo)
			sat_cam = lo[PT_W-1:0];
		else
			sat_cam = v[PT_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] sat_pix(input logic signed [UPIX_W-1:0] v);
		logic signed [UPIX_W-1:0] hi;
		logic signed [UPIX_W-1:0] lo;
		hi = UPIX_W'(2 ** (PIX_W - 1) - 1);
		lo = -UPIX_W'(2 ** (PIX_W - 1));
		if (v > hi)
			sat_pix = hi[PIX_W-1:0];
		else if (v < lo)
			sat_pix = lo[PIX_W-1:0];
		else
			sat_pix = v[PIX_W-1:0];
	endfunction

endpackage

### hw/rtl/lpp_if.sv
// Point and pixel stream interfaces.
`timescale 1ns / 1ps
interface lpp_point_if;
	logic        valid;
	logic        ready;
	logic [23:0] point_x;
	logic [23:0] point_y;
	logic [23:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface lpp_pixel_if;
	logic        valid;
	logic        ready;
	logic [23:0] cam_x;
	logic [23:0] cam_y;
	logic [23:0] cam_z;
	logic [15:0] pixel_u;
	logic [15:0] pixel_v;
	logic [1:0]  status;
	modport source (output valid, cam_x, cam_y, cam_z, pixel_u, pixel_v, status, input ready);
	modport sink   (input valid, cam_x, cam_y, cam_z, pixel_u, pixel_v, status, output ready);
endinterface

### hw/rtl/lpp_div.sv
// Pipelined restoring divider, one quotient bit per stage, clamped quotient.
`timescale 1ns / 1ps
module lpp_div
	import lpp_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [PT_W-1:0]  den,
	input  logic             ovf,
	output logic [Q_W-1:0]   quo
);

	logic [NUM_W-1:0]     rem_s [DIV_STEPS];
	logic [PT_W-1:0]      den_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] q_s   [DIV_STEPS];
	logic                 ovf_s [DIV_STEPS];

	genvar k;
	generate
		for (k = 0; k < DIV_STEPS; k++) begin : g_step
			logic [NUM_W-1:0]     rem_in;
			logic [PT_W-1:0]      den_in;
			logic [DIV_STEPS-1:0] q_in;
			logic                 ovf_in;
			logic [NUM_W-1:0]     trial;
			if (k == 0) begin : g_first
				assign rem_in = num;
				assign den_in = den;
				assign q_in   = '0;
				assign ovf_in = ovf;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign den_in = den_s[k-1];
				assign q_in   = q_s[k-1];
				assign ovf_in = ovf_s[k-1];
			end
			assign trial = NUM_W'(den_in) << (DIV_STEPS - 1 - k);
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k] <= den_in;
					ovf_s[k] <= ovf_in;
					if (rem_in >= trial) begin
						rem_s[k] <= rem_in - trial;
						q_s[k]   <= q_in | (DIV_STEPS'(1) << (DIV_STEPS - 1 - k));
					end else begin
						rem_s[k] <= rem_in;
						q_s[k]   <= q_in;
					end
				end
			end
		end
	endgenerate

	// clamp at 2^DIV_STEPS: any larger quotient lands far outside the image
	assign quo = ovf_s[DIV_STEPS-1] ? Q_W'(1) << DIV_STEPS : {1'b0, q_s[DIV_STEPS-1]};

endmodule

### hw/rtl/lidar_point_to_pixel_projection.sv
// Top level of the lidar point to camera pixel projection pipeline.
`timescale 1ns / 1ps
// Projects lidar points through a pinhole camera model. One point is accepted
// per clock and one result leaves per clock unless the output stalls. A point
// passes five arithmetic stages (multiply, sum and round, depth test with
// focal multiply, magnitude, dividend), 21 divider stages that each resolve
// one quotient bit, and the output stage, ending in the result register.
// The divider sets the depth. A stall at the output freezes the whole pipe,
// so points.ready follows pixels.ready whenever the output register is full.
// Configuration sits on an APB port, registers at byte address 8*index with
// 64-bit data; write it only while no point is in flight.
module lidar_point_to_pixel_projection
	import lpp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	lpp_point_if.sink          points,
	lpp_pixel_if.source        pixels
);

	// ---------------- configuration registers ----------------
	logic [47:0] rot_q [3];
	logic [47:0] trans_q;
	logic [31:0] focal_q;
	logic [31:0] prin_q;
	logic [31:0] img_q;
	logic [15:0] maxd_q;
	lpp_reg_t    reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = lpp_reg_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= 48'h0000_4000_0000;
			rot_q[1] <= 48'h0000_4000_0000;
			rot_q[2] <= 48'h0000_0000_4000;
			trans_q  <= '0;
			focal_q  <= '0;
			prin_q   <= '0;
			img_q    <= '0;
			maxd_q   <= 16'hFFFF;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_ROT0:  rot_q[0] <= pwdata[47:0];
				REG_ROT1:  rot_q[1] <= pwdata[47:0];
				REG_ROT2:  rot_q[2] <= pwdata[47:0];
				REG_TRANS: trans_q  <= pwdata[47:0];
				REG_FOCAL: focal_q  <= pwdata[31:0];
				REG_PRIN:  prin_q   <= pwdata[31:0];
				REG_IMG:   img_q    <= pwdata[31:0];
				REG_MAXD:  maxd_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROT0:  prdata = {16'b0, rot_q[0]};
			REG_ROT1:  prdata = {16'b0, rot_q[1]};
			REG_ROT2:  prdata = {16'b0, rot_q[2]};
			REG_TRANS: prdata = {16'b0, trans_q};
			REG_FOCAL: prdata = {32'b0, focal_q};
			REG_PRIN:  prdata = {32'b0, prin_q};
			REG_IMG:   prdata = {32'b0, img_q};
			REG_MAXD:  prdata = {48'b0, maxd_q};
			default:   prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// One enable for every stage: advance unless the output register is held.
	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [DIV_STEPS-1:0] valid_d;

	assign en           = !valid_s6 || pixels.ready;
	assign points.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_d  <= '0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= points.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_d  <= {valid_d[DIV_STEPS-2:0], valid_s5};
			valid_s6 <= valid_d[DIV_STEPS-1];
		end
	end

	// ---------------- stage 1: nine rotation products ----------------
	logic signed [PT_W-1:0]   pt_in [3];
	logic signed [PROD_W-1:0] prod_s1 [3][3];

	assign pt_in[0] = points.point_x;
	assign pt_in[1] = points.point_y;
	assign pt_in[2] = points.point_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++)
				for (int c = 0; c < 3; c++)
					prod_s1[a][c] <= $signed(rot_q[a][16*c +: 16]) * pt_in[c];
		end
	end

	// ---------------- stage 2: sum, add translation, round to Q8.16 ----------------
	logic signed [ACC_W-1:0] acc [3];
	logic signed [CAM_W-1:0] cam_s2 [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			// translation Q8.8 sits 22 bits up in the Q.30 sum; add half an LSB to round
			acc[a] = ACC_W'(prod_s1[a][0]) + ACC_W'(prod_s1[a][1]) + ACC_W'(prod_s1[a][2])
				+ (ACC_W'($signed(trans_q[16*a +: 16])) <<< 22) + ACC_W'(1 << 13);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++)
				cam_s2[a] <= acc[a][ACC_W-1:14];
		end
	end

	// ---------------- stage 3: depth test, saturation, focal multiply ----------------
	lpp_side_t               side_s3;
	logic signed [NUM_W-1:0] nu_s3, nv_s3;
	logic [PT_W-1:0]         z_s3;
	logic signed [CAM_W-1:0] max_z;

	assign max_z = $signed(CAM_W'({maxd_q, 8'b0}));

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.cam_x      <= sat_cam(cam_s2[0]);
			side_s3.cam_y      <= sat_cam(cam_s2[1]);
			side_s3.cam_z      <= sat_cam(cam_s2[2]);
			side_s3.depth_bad  <= (cam_s2[2] < 0) || (cam_s2[2] > max_z);
			side_s3.depth_zero <= (cam_s2[2] == 0);
			side_s3.neg_u      <= 1'b0;
			side_s3.neg_v      <= 1'b0;
			z_s3  <= cam_s2[2][PT_W-1:0];
			nu_s3 <= $signed({1'b0, focal_q[15:0]}) * cam_s2[0];
			nv_s3 <= $signed({1'b0, focal_q[31:16]}) * cam_s2[1];
		end
	end

	// ---------------- stage 4: magnitudes ----------------
	lpp_side_t        side_s4;
	logic [NUM_W-1:0] mu_s4, mv_s4;
	logic [PT_W-1:0]  z_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.cam_x      <= side_s3.cam_x;
			side_s4.cam_y      <= side_s3.cam_y;
			side_s4.cam_z      <= side_s3.cam_z;
			side_s4.depth_bad  <= side_s3.depth_bad;
			side_s4.depth_zero <= side_s3.depth_zero;
			side_s4.neg_u      <= nu_s3 < 0;
			side_s4.neg_v      <= nv_s3 < 0;
			mu_s4 <= (nu_s3 < 0) ? NUM_W'(-nu_s3) : NUM_W'(nu_s3);
			mv_s4 <= (nv_s3 < 0) ? NUM_W'(-nv_s3) : NUM_W'(nv_s3);
			z_s4  <= z_s3;
		end
	end

	// ---------------- stage 5: rounded dividend and overflow check ----------------
	lpp_side_t        side_s5;
	logic [NUM_W-1:0] numu_s5, numv_s5;
	logic             ovfu_s5, ovfv_s5;
	logic [PT_W-1:0]  z_s5;
	logic [NUM_W-1:0] numu, numv, zlim;

	assign numu = mu_s4 + NUM_W'(z_s4 >> 1);
	assign numv = mv_s4 + NUM_W'(z_s4 >> 1);
	assign zlim = NUM_W'(z_s4) << DIV_STEPS;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			numu_s5 <= numu;
			numv_s5 <= numv;
			ovfu_s5 <= numu >= zlim;
			ovfv_s5 <= numv >= zlim;
			z_s5    <= z_s4;
		end
	end

	// ---------------- divider stages ----------------
	lpp_side_t      side_d [DIV_STEPS];
	logic [Q_W-1:0] qu, qv;

	lpp_div u_div_u (.clk(clk), .en(en), .num(numu_s5), .den(z_s5), .ovf(ovfu_s5), .quo(qu));
	lpp_div u_div_v (.clk(clk), .en(en), .num(numv_s5), .den(z_s5), .ovf(ovfv_s5), .quo(qv));

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s5;
			for (int k = 1; k < DIV_STEPS; k++)
				side_d[k] <= side_d[k-1];
		end
	end

	// ---------------- stage 6: principal point, bounds, output register ----------------
	lpp_side_t               side_f;
	logic signed [UPIX_W-1:0] u_full, v_full, w_lim, h_lim;
	logic                    in_image;
	lpp_status_t             status_s6;
	logic [PT_W-1:0]         cam_x_s6, cam_y_s6, cam_z_s6;
	logic [PIX_W-1:0]        pixel_u_s6, pixel_v_s6;

	assign side_f = side_d[DIV_STEPS-1];
	assign u_full = side_f.neg_u
		? $signed(UPIX_W'(prin_q[15:0])) - $signed(UPIX_W'(qu))
		: $signed(UPIX_W'(prin_q[15:0])) + $signed(UPIX_W'(qu));
	assign v_full = side_f.neg_v
		? $signed(UPIX_W'(prin_q[31:16])) - $signed(UPIX_W'(qv))
		: $signed(UPIX_W'(prin_q[31:16])) + $signed(UPIX_W'(qv));
	assign w_lim  = $signed(UPIX_W'({img_q[15:0], 4'b0}));
	assign h_lim  = $signed(UPIX_W'({img_q[31:16], 4'b0}));
	// strict on both sides, so an empty image never shows a point
	assign in_image = (u_full > 0) && (u_full < w_lim) && (v_full > 0) && (v_full < h_lim);

	always_ff @(posedge clk) begin
		if (en) begin
			cam_x_s6 <= side_f.cam_x;
			cam_y_s6 <= side_f.cam_y;
			cam_z_s6 <= side_f.cam_z;
			if (side_f.depth_bad) begin
				status_s6  <= ST_DEPTH_BAD;
				pixel_u_s6 <= '0;
				pixel_v_s6 <= '0;
			end else if (side_f.depth_zero) begin
				status_s6  <= ST_OUTSIDE;
				pixel_u_s6 <= '0;
				pixel_v_s6 <= '0;
			end else begin
				status_s6  <= in_image ? ST_VISIBLE : ST_OUTSIDE;
				pixel_u_s6 <= sat_pix(u_full);
				pixel_v_s6 <= sat_pix(v_full);
			end
		end
	end

	assign pixels.valid   = valid_s6;
	assign pixels.cam_x   = cam_x_s6;
	assign pixels.cam_y   = cam_y_s6;
	assign pixels.cam_z   = cam_z_s6;
	assign pixels.pixel_u = pixel_u_s6;
	assign pixels.pixel_v = pixel_v_s6;
	assign pixels.status  = status_s6;

endmodule

### hw/rtl/lpp_checker.sv
// Port-level assertions for the projection block, bound to its top level.
`timescale 1ns / 1ps
module lpp_checker
	import lpp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] pixel_u,
	input logic [15:0] pixel_v,
	input logic [1:0]  status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_u) && $stable(status))
		else $error("held request changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_VISIBLE || status == ST_DEPTH_BAD || status == ST_OUTSIDE)
		else $error("bad status code");

	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DEPTH_BAD |-> pixel_u == 16'd0 && pixel_v == 16'd0)
		else $error("rejected depth with nonzero pixel");

	a_vis_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_VISIBLE |-> !pixel_u[15] && pixel_u != 16'd0
			&& !pixel_v[15] && pixel_v != 16'd0)
		else $error("visible pixel not inside");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind lidar_point_to_pixel_projection lpp_checker u_lpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (points.ready),
	.out_valid(pixels.valid),
	.out_ready(pixels.ready),
	.pixel_u  (pixels.pixel_u),
	.pixel_v  (pixels.pixel_v),
	.status   (pixels.status)
);
